@@ src/csm_pkg.sv @@
// Shared types and constants for the checked stack machine.
// Used by csm_alu, checked_stack_machine and csm_checker; no dependencies.
`timescale 1ns / 1ps

package csm_pkg;

    // Field widths
    localparam int DATA_W  = 31;
    localparam int LIMIT_W = 30;
    localparam int MODE_W  = 4;

    // Default stack size and reset value of the magnitude limit
    localparam int                 STACK_DEPTH_DEFAULT = 1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET         = 30'd1000000000;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_START  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_NUM    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_POP    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_INV    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DUP    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SWP    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ADD    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SUB    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_MUL    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_DIV    = 4'd9;
    localparam logic [MODE_W-1:0] MODE_MOD    = 4'd10;
    localparam logic [MODE_W-1:0] MODE_FINISH = 4'd11;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic              start;
        logic [MODE_W-1:0] op;
    } alu_req_t;

    // Completion status from the arithmetic unit
    typedef struct packed {
        logic done;
        logic fault;
    } alu_rsp_t;

endpackage

@@ src/checked_stack_machine.sv @@
// Top level of the checked stack machine: stack memory, command sequencer,
// output register. Depends on csm_pkg and csm_alu.
//
//  channel   direction  payload                                   accepted when
//  s_        in         tdata: operand[30:0]; tuser: mode[3:0]    s_tvalid & s_tready
//  m_        out        tdata: result_value[30:0]; tuser: error   m_tvalid & m_tready
//  cfg_      in         cfg_wdata: magnitude_limit[29:0]          cfg_wen
//
// Finished on acceptance: START, NUM, INV, DUP, POP of the last entry, ignored codes and
// commands that fail their depth check. Other POPs and SWP add a registered stack memory
// read; FINISH adds any wait for the output register; ADD, SUB, MUL, DIV and MOD also wait
// for the shared arithmetic unit, whose MUL, DIV and MOD run a 31-step shift-add/subtract
// loop and whose DIV or MOD by zero fails at once.
// Reset is synchronous, active low, and empties the stack at once (no clearing pass).
// s_tready is low while a command is in progress; a waiting result stalls only FINISH.
`timescale 1ns / 1ps

module checked_stack_machine #(
    parameter int STACK_DEPTH = csm_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [30:0] operand
    input  logic [csm_pkg::MODE_W-1:0]  s_tuser,   // [3:0] mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [30:0] result_value
    output logic                        m_tuser,   // [0] error
    input  logic                        cfg_wen,
    input  logic [csm_pkg::LIMIT_W-1:0] cfg_wdata  // magnitude_limit
);
    import csm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
    localparam logic [DW-1:0] D_ONE      = DW'(1);
    localparam logic [DW-1:0] D_TWO      = DW'(2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [DW-1:0]           depth_reg, depth_next;
    logic                    err_reg, err_next;
    logic [DATA_W-1:0]       tos_reg, tos_next;
    logic [LIMIT_W-1:0]      limit_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]       out_value_reg, out_value_next;
    logic                    out_err_reg, out_err_next;

    // Stack memory holds every entry below the top of stack
    logic [DATA_W-1:0]       mem [STACK_DEPTH];
    logic [DATA_W-1:0]       rd_data_reg;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic [DATA_W-1:0]       mem_wdata;

    logic                    accept;
    logic [MODE_W-1:0]       in_mode;
    logic [DATA_W-1:0]       in_operand;
    logic [DW-1:0]           depth_m1, depth_m2;
    logic                    fin_fail;

    alu_req_t                alu_req;
    alu_rsp_t                alu_rsp;
    logic [DATA_W-1:0]       alu_result;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_mode    = s_tuser;
    assign in_operand = s_tdata[DATA_W-1:0];
    assign depth_m1   = depth_reg - D_ONE;
    assign depth_m2   = depth_reg - D_TWO;
    assign mem_raddr  = depth_m2[AW-1:0];
    assign fin_fail   = err_reg || (depth_reg != D_ONE);

    // Command sequencer
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        tos_next       = tos_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = depth_m1[AW-1:0];
        mem_wdata      = tos_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = mode_reg;

        // Drop the output item once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next = in_mode;
                    priority if (in_mode == MODE_START) begin
                        depth_next = D_ONE;
                        err_next   = 1'b0;
                        tos_next   = in_operand;
                    end else if (in_mode == MODE_FINISH) begin
                        state_next = S_FIN;
                    end else if (!err_reg) begin
                        unique case (in_mode)
                            MODE_NUM, MODE_DUP: begin
                                if (depth_reg == DEPTH_FULL ||
                                    (in_mode == MODE_DUP && depth_reg == '0)) begin
                                    err_next = 1'b1;
                                end else begin
                                    // Spill the old top, push the new one
                                    mem_we     = (depth_reg != '0);
                                    depth_next = depth_reg + D_ONE;
                                    if (in_mode == MODE_NUM) begin
                                        tos_next = in_operand;
                                    end
                                end
                            end
                            MODE_POP: begin
                                priority if (depth_reg == '0) begin
                                    err_next = 1'b1;
                                end else if (depth_reg == D_ONE) begin
                                    depth_next = '0;
                                end else begin
                                    state_next = S_RD;
                                end
                            end
                            MODE_INV: begin
                                if (depth_reg == '0) begin
                                    err_next = 1'b1;
                                end else begin
                                    tos_next = DATA_W'(0) - tos_reg;
                                end
                            end
                            MODE_SWP, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
                            MODE_MOD: begin
                                if (depth_reg < D_TWO) begin
                                    err_next = 1'b1;
                                end else begin
                                    state_next = S_RD;
                                end
                            end
                            default: begin
                                // Unused codes leave the state alone
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                // Fetch the entry under the top
                mem_re     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                unique case (mode_reg)
                    MODE_POP: begin
                        tos_next   = rd_data_reg;
                        depth_next = depth_m1;
                        state_next = S_IDLE;
                    end
                    MODE_SWP: begin
                        mem_we     = 1'b1;
                        mem_waddr  = depth_m2[AW-1:0];
                        tos_next   = rd_data_reg;
                        state_next = S_IDLE;
                    end
                    default: begin
                        alu_req.start = 1'b1;
                        state_next    = S_ALU;
                    end
                endcase
            end
            S_ALU: begin
                // Wait for the arithmetic unit; on a fault keep the stack as it was
                if (alu_rsp.done) begin
                    if (alu_rsp.fault) begin
                        err_next = 1'b1;
                    end else begin
                        tos_next   = alu_result;
                        depth_next = depth_m1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIN: begin
                // Load the result once the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_value_next = fin_fail ? '0 : tos_reg;
                    out_err_next   = fin_fail;
                    depth_next     = '0;
                    err_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
        end
        mode_reg      <= mode_next;
        tos_reg       <= tos_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    csm_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .left    (rd_data_reg),
        .right   (tos_reg),
        .limit   (limit_reg),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg};
    assign m_tuser  = out_err_reg;

endmodule

@@ src/csm_alu.sv @@
// Shared iterative arithmetic unit: add/sub, shift-add multiply, restoring divide,
// followed by a magnitude-limit check. Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_alu (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  csm_pkg::alu_req_t                 req,
    input  logic signed [csm_pkg::DATA_W-1:0] left,
    input  logic signed [csm_pkg::DATA_W-1:0] right,
    input  logic [csm_pkg::LIMIT_W-1:0]       limit,
    output csm_pkg::alu_rsp_t                 rsp,
    output logic signed [csm_pkg::DATA_W-1:0] result
);
    import csm_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    localparam logic [2:0] A_IDLE  = 3'd0;
    localparam logic [2:0] A_SIGN  = 3'd1;
    localparam logic [2:0] A_MUL   = 3'd2;
    localparam logic [2:0] A_DIV   = 3'd3;
    localparam logic [2:0] A_CHECK = 3'd4;

    logic [2:0]        st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MODE_W-1:0] op_reg, op_next;
    logic [DATA_W:0]   hi_reg, hi_next;      // accumulator / remainder / add result
    logic [DATA_W-1:0] lo_reg, lo_next;      // multiplier / quotient bits
    logic [DATA_W-1:0] mcand_reg, mcand_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic              fault_reg, fault_next;
    logic [DATA_W-1:0] res_reg, res_next;

    logic [DATA_W:0]   a_ext, b_ext, a_abs, b_abs, sum_ext, sum_abs;
    logic [DATA_W:0]   mul_sum, div_shift;
    logic [DATA_W+1:0] div_trial;
    logic [DATA_W:0]   mag_hi;
    logic [DATA_W-1:0] mag_lo;
    logic              over;

    always_comb begin
        // Operand preparation
        a_ext   = {left[DATA_W-1], left};
        b_ext   = {right[DATA_W-1], right};
        a_abs   = left[DATA_W-1]  ? ((DATA_W+1)'(0) - a_ext) : a_ext;
        b_abs   = right[DATA_W-1] ? ((DATA_W+1)'(0) - b_ext) : b_ext;
        sum_ext = (req.op == MODE_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
        sum_abs = hi_reg[DATA_W] ? ((DATA_W+1)'(0) - hi_reg) : hi_reg;

        // One multiply or divide step
        mul_sum   = hi_reg + (lo_reg[0] ? {1'b0, mcand_reg} : (DATA_W+1)'(0));
        div_shift = {hi_reg[DATA_W-1:0], lo_reg[DATA_W-1]};
        div_trial = {1'b0, div_shift} - {2'b00, mcand_reg};

        // Magnitude selection for the limit check
        unique case (op_reg)
            MODE_DIV: begin
                mag_hi = '0;
                mag_lo = lo_reg;
            end
            MODE_MOD: begin
                mag_hi = '0;
                mag_lo = hi_reg[DATA_W-1:0];
            end
            default: begin
                mag_hi = hi_reg;
                mag_lo = lo_reg;
            end
        endcase
        over = (mag_hi != '0) || (mag_lo > {1'b0, limit});

        st_next    = st_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        fault_next = fault_reg;
        res_next   = res_reg;

        unique case (st_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next    = req.op;
                    cnt_next   = LAST_STEP;
                    lo_next    = a_abs[DATA_W-1:0];
                    mcand_next = b_abs[DATA_W-1:0];
                    hi_next    = '0;
                    priority if (req.op == MODE_ADD || req.op == MODE_SUB) begin
                        hi_next = sum_ext;
                        st_next = A_SIGN;
                    end else if (req.op == MODE_MUL) begin
                        neg_next = left[DATA_W-1] ^ right[DATA_W-1];
                        st_next  = A_MUL;
                    end else if (right == '0) begin
                        // Zero divisor: fail at once
                        fault_next = 1'b1;
                        done_next  = 1'b1;
                    end else begin
                        neg_next = (req.op == MODE_DIV) ?
                                   (left[DATA_W-1] ^ right[DATA_W-1]) : left[DATA_W-1];
                        st_next  = A_DIV;
                    end
                end
            end
            A_SIGN: begin
                // Split the sum into sign and magnitude
                neg_next = hi_reg[DATA_W];
                hi_next  = {{DATA_W{1'b0}}, sum_abs[DATA_W]};
                lo_next  = sum_abs[DATA_W-1:0];
                st_next  = A_CHECK;
            end
            A_MUL: begin
                // Add and shift right one multiplier bit
                hi_next  = {1'b0, mul_sum[DATA_W:1]};
                lo_next  = {mul_sum[0], lo_reg[DATA_W-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    st_next = A_CHECK;
                end
            end
            A_DIV: begin
                // Trial subtract, keep or restore, shift in a quotient bit
                if (!div_trial[DATA_W+1]) begin
                    hi_next = div_trial[DATA_W:0];
                end else begin
                    hi_next = div_shift;
                end
                lo_next  = {lo_reg[DATA_W-2:0], ~div_trial[DATA_W+1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    st_next = A_CHECK;
                end
            end
            A_CHECK: begin
                fault_next = over;
                res_next   = neg_reg ? (DATA_W'(0) - mag_lo) : mag_lo;
                done_next  = 1'b1;
                st_next    = A_IDLE;
            end
            default: begin
                st_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= A_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        cnt_reg   <= cnt_next;
        op_reg    <= op_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
        neg_reg   <= neg_next;
        fault_reg <= fault_next;
        res_reg   <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.fault = fault_reg;
    assign result    = res_reg;

endmodule

@@ src/csm_checker.sv @@
// Port-level checks for the checked stack machine, bound to the top level.
// Depends on csm_pkg and checked_stack_machine.
`timescale 1ns / 1ps

module csm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [csm_pkg::MODE_W-1:0] s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [31:0]                m_tdata,
    input logic                       m_tuser
);
    import csm_pkg::*;

    // No output item right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output item present after reset");

    // A stalled output item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output item changed");

    // An error item carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("error item with nonzero value");

    // Only FINISH produces an output item
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != MODE_FINISH && !m_tvalid |=> !m_tvalid)
        else $error("output item without finish");

    // FINISH takes the sequencer out of ready once accepted
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_FINISH |=> !s_tready)
        else $error("ready right after finish");

endmodule

bind checked_stack_machine csm_checker u_csm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ bench/tb_top.sv @@
// Self-checking bench for checked_stack_machine: drives command programs, predicts results.
// Depends on csm_pkg and the checked_stack_machine RTL only.
`timescale 1ns / 1ps

module tb_top;
    import csm_pkg::*;

    localparam int  CYCLE_LIMIT   = 1500000;
    localparam int  SETTLE_CYCLES = 48;
    localparam int  HOLD_CYCLES   = 400;
    localparam logic signed [DATA_W-1:0] OPND_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] OPND_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] BILLION  = 31'sd1000000000;
    localparam logic [LIMIT_W-1:0]       LIMIT_MAX = '1;

    // Stack calculator prediction and the queue of pending FINISH results
    class stack_calc_board;
        logic signed [DATA_W-1:0] stk [STACK_DEPTH_DEFAULT];
        int unsigned              depth;
        bit                       err;
        logic [LIMIT_W-1:0]       lim;
        logic [DATA_W-1:0]        want_value [$];
        bit                       want_error [$];
        int                       mismatches;
        int                       checked;

        function new();
            depth      = 0;
            err        = 0;
            lim        = LIMIT_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            lim = v;
        endfunction

        function int pending();
            return want_value.size();
        endfunction

        function void push(logic signed [DATA_W-1:0] v);
            if (depth >= STACK_DEPTH_DEFAULT) begin
                err = 1;
                return;
            end
            stk[depth] = v;
            depth++;
        endfunction

        // Binary arithmetic: top is the right operand, the entry below is the left
        function void arith(logic [MODE_W-1:0] mode);
            longint left, right, res, bound;
            if (depth < 2) begin
                err = 1;
                return;
            end
            right = stk[depth-1];
            left  = stk[depth-2];
            bound = longint'(lim);
            case (mode)
                MODE_ADD: res = left + right;
                MODE_SUB: res = left - right;
                MODE_MUL: res = left * right;
                default: begin
                    if (right == 0) begin
                        err = 1;
                        return;
                    end
                    res = (mode == MODE_DIV) ? left / right : left % right;
                end
            endcase
            if (res > bound || res < -bound) begin
                err = 1;
                return;
            end
            depth--;
            stk[depth-1] = res[DATA_W-1:0];
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] opnd);
            logic signed [DATA_W-1:0] t;
            if (mode == MODE_START) begin
                depth = 0;
                err   = 0;
                push(opnd);
                return;
            end
            if (mode == MODE_FINISH) begin
                if (err || depth != 1) begin
                    want_value.push_back('0);
                    want_error.push_back(1'b1);
                end else begin
                    want_value.push_back(stk[0]);
                    want_error.push_back(1'b0);
                end
                depth = 0;
                err   = 0;
                return;
            end
            // Unused codes and everything after a fault are dropped
            if (mode > MODE_FINISH || err)
                return;
            case (mode)
                MODE_NUM: push(opnd);
                MODE_POP: begin
                    if (depth == 0) err = 1;
                    else depth--;
                end
                MODE_INV: begin
                    if (depth == 0) err = 1;
                    else stk[depth-1] = -stk[depth-1];
                end
                MODE_DUP: begin
                    if (depth == 0) err = 1;
                    else push(stk[depth-1]);
                end
                MODE_SWP: begin
                    if (depth < 2) begin
                        err = 1;
                    end else begin
                        t            = stk[depth-1];
                        stk[depth-1] = stk[depth-2];
                        stk[depth-2] = t;
                    end
                end
                default: arith(mode);
            endcase
        endfunction

        function void check_result(logic [DATA_W-1:0] value, logic error);
            logic [DATA_W-1:0] ev;
            bit                ee;
            if (want_value.size() == 0) begin
                $error("result with nothing expected: result_value %0d error %0b",
                       $signed(value), error);
                mismatches++;
                return;
            end
            ev = want_value.pop_front();
            ee = want_error.pop_front();
            checked++;
            if (value !== ev) begin
                $error("result_value: expected %0d, got %0d", $signed(ev), $signed(value));
                mismatches++;
            end
            if (error !== ee) begin
                $error("error: expected %0b, got %0b", ee, error);
                mismatches++;
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata   = '0;   // [30:0] operand
    logic [MODE_W-1:0]   s_tuser   = '0;   // [3:0] mode
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;          // [30:0] result_value
    logic                m_tuser;          // [0] error
    logic                cfg_wen   = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wdata = '0;

    stack_calc_board board = new();

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req     = 1'b0;
    int stall_left   = 0;
    int cmds_sent    = 0;
    int limits_used  = 1;
    int cycles       = 0;

    checked_stack_machine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("checked_stack_machine: mismatch");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'(int'($urandom_range(0, 40)) - 20);
            4:          return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
            5, 6:       return DATA_W'(int'($urandom_range(0, 100000)) - 50000);
            7:          return DATA_W'($urandom());
            default: begin
                case ($urandom_range(0, 5))
                    0:       return BILLION;
                    1:       return -BILLION;
                    2:       return OPND_MIN;
                    3:       return OPND_MAX;
                    4:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Choose a command that mostly keeps the stack well formed
    function automatic logic [MODE_W-1:0] pick_mode(int d);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return MODE_W'($urandom_range(MODE_NUM, MODE_MOD));
        if (d < 2) begin
            r = $urandom_range(0, 99);
            if (r < 60) return MODE_NUM;
            if (r < 85) return MODE_DUP;
            return MODE_INV;
        end
        case ($urandom_range(0, 11))
            0, 11:   return MODE_NUM;
            1:       return MODE_POP;
            2:       return MODE_INV;
            3:       return MODE_DUP;
            4:       return MODE_SWP;
            5:       return MODE_ADD;
            6:       return MODE_SUB;
            7:       return MODE_MUL;
            8:       return MODE_DIV;
            9:       return MODE_MOD;
            default: return MODE_ADD;
        endcase
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] opnd);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, opnd};
        do @(posedge aclk); while (!s_tready);
        board.note_command(mode, opnd);
        cmds_sent++;
    endtask

    // Stop offering and wait for every pending result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // Write the limit once the block is idle
    task automatic write_limit(logic [LIMIT_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        board.set_limit(v);
        limits_used++;
    endtask

    // One program: START, a run of commands, usually FINISH
    task automatic run_program();
        int                len, d;
        logic [MODE_W-1:0] m;
        len = $urandom_range(1, 12);
        d   = 1;
        send_item(MODE_START, pick_operand());
        repeat (len) begin
            m = pick_mode(d);
            send_item(m, pick_operand());
            case (m)
                MODE_NUM, MODE_DUP: d++;
                MODE_POP:           d = (d > 0) ? d - 1 : 0;
                MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: d = (d > 1) ? d - 1 : d;
                default: ;
            endcase
        end
        if ($urandom_range(0, 15) == 0)
            send_item(MODE_W'($urandom_range(int'(MODE_FINISH) + 1, (1 << MODE_W) - 1)),
                      pick_operand());
        if ($urandom_range(0, 9) != 0)
            send_item(MODE_FINISH, pick_operand());
        if ($urandom_range(0, 19) == 0)
            send_item(MODE_FINISH, pick_operand());
    endtask

    task automatic run_programs(int count);
        int stop_at;
        stop_at = cmds_sent + count;
        while (cmds_sent < stop_at) run_program();
    endtask

    // Result side: check accepted items, then choose ready for the next cycle
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_result(m_tdata[DATA_W-1:0], m_tuser);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap(sink_idle_on);
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every command, extremes and the corner cases
        send_item(MODE_START, -BILLION);
        send_item(MODE_NUM, BILLION);
        send_item(MODE_ADD, '0);
        send_item(MODE_NUM, -31'sd17);
        send_item(MODE_NUM, 31'sd5);
        send_item(MODE_MOD, '0);          // remainder keeps the dividend's sign
        send_item(MODE_SWP, '0);
        send_item(MODE_POP, '0);
        send_item(MODE_DUP, '0);
        send_item(MODE_MUL, '0);
        send_item(MODE_INV, '0);
        send_item(MODE_NUM, 31'sd7);
        send_item(MODE_SUB, '0);
        send_item(MODE_FINISH, '0);
        send_item(MODE_POP, '0);          // underflow on an empty stack
        send_item(MODE_FINISH, '0);
        send_item(MODE_START, OPND_MIN);  // beyond the limit, pushed unchecked
        send_item(MODE_INV, '0);          // negation wraps back to itself
        send_item(MODE_NUM, '1);
        send_item(MODE_DIV, '0);          // quotient 2^30 exceeds any limit
        send_item(MODE_W'(int'(MODE_FINISH) + 1), OPND_MAX);
        send_item(MODE_FINISH, '0);
        send_item(MODE_START, '0);
        send_item(MODE_DUP, '0);
        send_item(MODE_DIV, '0);          // zero divisor
        send_item(MODE_FINISH, '0);

        // Widest limit, idling on both sides
        write_limit(LIMIT_MAX);
        run_programs(120);

        // Long receiver hold-off while programs keep coming
        hold_req = 1'b1;
        run_programs(60);
        drain_results();
        run_programs(40);

        // Zero limit, no idling
        write_limit('0);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_programs(60);

        write_limit(30'd1000);
        sink_idle_on = 1'b1;
        run_programs(100);

        write_limit(LIMIT_W'($urandom_range(0, int'(LIMIT_MAX))));
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b0;
        run_programs(80);

        // Back at the reset limit
        write_limit(LIMIT_RESET);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        run_programs(80);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.pending() != 0) begin
            $error("%0d results never arrived", board.pending());
            board.mismatches++;
        end

        $display("ran %0d commands, checked %0d results under %0d limit values",
                 cmds_sent, board.checked, limits_used);
        $display("covered every command, underflow, zero divisor, limit faults,"
                 , " long output stall and idle-free stretches");
        if (board.mismatches == 0)
            $display("checked_stack_machine: match");
        else
            $display("checked_stack_machine: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
src/csm_pkg.sv
src/csm_alu.sv
src/checked_stack_machine.sv
src/csm_checker.sv
bench/tb_top.sv
